// File: src/anger_event_merge_core_assert.svh
// Assertion macros shared by the anger event merge RTL.
`ifndef ANGER_EVENT_MERGE_CORE_ASSERT_SVH
`define ANGER_EVENT_MERGE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define AEM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define AEM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: src/aem_pkg.sv
// Types, constants and codes of the anger event merge block.
package aem_pkg;

    localparam int NUM_DET     = 1024;
    localparam int COORD_BITS  = 6;
    localparam int ENERGY_BITS = 24;

    localparam int ID_W      = 10;
    localparam int ADDR_W    = $clog2(NUM_DET);
    localparam int SIZE_W    = 7;
    localparam int CNT_W     = 11;
    localparam int MODE_W    = 2;
    localparam int ESUM_W    = ENERGY_BITS + 1;
    localparam int PROD_W    = ENERGY_BITS + COORD_BITS;
    localparam int DIV_W     = PROD_W + 3;
    localparam int DEN_W     = ENERGY_BITS + 2;
    localparam int T1_W      = ID_W + SIZE_W;
    localparam int T2_W      = T1_W + SIZE_W;
    localparam int POS_W     = T2_W + SIZE_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MAX   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ANGER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MERGE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DET_COUNT  = 3'd4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_DUP      = 2'd2,
        ST_UNMAPPED = 2'd3
    } status_t;

    typedef struct packed {
        logic                   cmd;
        logic [ID_W-1:0]        det_a;
        logic [23:0]            energy_a;
        logic [ID_W-1:0]        det_b;
        logic [23:0]            energy_b;
        logic [ID_W-1:0]        map_block;
        logic [5:0]             map_x;
        logic [5:0]             map_y;
        logic [5:0]             map_z;
    } in_word_t;

    typedef struct packed {
        status_t                status;
        logic                   keep_first;
        logic [ID_W-1:0]        merged_det;
        logic [ESUM_W-1:0]      merged_energy;
    } out_word_t;

    typedef struct packed {
        logic [ID_W-1:0]        blk;
        logic [COORD_BITS-1:0]  x;
        logic [COORD_BITS-1:0]  y;
        logic [COORD_BITS-1:0]  z;
    } map_entry_t;

    typedef struct packed {
        logic                   valid;
        logic [ID_W-1:0]        id;
    } rev_entry_t;

    // Item context that rides alongside the arithmetic.
    typedef struct packed {
        logic                   is_load;
        logic                   anger;
        logic                   id_ok;
        logic                   s_zero;
        logic                   keep;
        logic [ID_W-1:0]        det_a;
        logic [ID_W-1:0]        det_b;
        logic [ESUM_W-1:0]      esum;
        map_entry_t             pos;
    } side_t;

endpackage

// File: src/aem_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module aem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/aem_cdiv.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
module aem_cdiv #(
    parameter int SIDE_W = 8
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      en,
    input  logic                                      in_valid,
    input  logic [2:0][aem_pkg::DIV_W-1:0]            num,
    input  logic [aem_pkg::DEN_W-1:0]                 den,
    input  logic [SIDE_W-1:0]                         side_in,
    output logic                                      out_valid,
    output logic [2:0][aem_pkg::COORD_BITS-1:0]       quo,
    output logic [SIDE_W-1:0]                         side_out
);

    import aem_pkg::*;

    localparam int STAGES = COORD_BITS;

    logic [STAGES-1:0]                 vld_reg;
    logic [2:0][DIV_W-1:0]             rem_reg  [STAGES-1];
    logic [2:0][COORD_BITS-1:0]        q_reg    [STAGES];
    logic [DEN_W-1:0]                  den_reg  [STAGES];
    logic [SIDE_W-1:0]                 side_reg [STAGES];

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        logic                          vld_prev;
        logic [2:0][DIV_W-1:0]         rem_prev;
        logic [2:0][COORD_BITS-1:0]    q_prev;
        logic [DEN_W-1:0]              den_prev;
        logic [SIDE_W-1:0]             side_prev;
        logic [DIV_W-1:0]              dsh;
        logic [2:0][DIV_W-1:0]         rem_next;
        logic [2:0][COORD_BITS-1:0]    q_next;

        if (g == 0)
        begin : g_first
            assign vld_prev  = in_valid;
            assign rem_prev  = num;
            assign q_prev    = '0;
            assign den_prev  = den;
            assign side_prev = side_in;
        end
        else
        begin : g_rest
            assign vld_prev  = vld_reg[g-1];
            assign rem_prev  = rem_reg[g-1];
            assign q_prev    = q_reg[g-1];
            assign den_prev  = den_reg[g-1];
            assign side_prev = side_reg[g-1];
        end

        // This stage decides quotient bit STAGES-1-g.
        assign dsh = DIV_W'(den_prev) << (STAGES - 1 - g);

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                q_next[l] = q_prev[l];
                if (rem_prev[l] >= dsh)
                begin
                    rem_next[l] = rem_prev[l] - dsh;
                    q_next[l][STAGES-1-g] = 1'b1;
                end
                else
                begin
                    rem_next[l] = rem_prev[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[g] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[g]    <= q_next;
                den_reg[g]  <= den_prev;
                side_reg[g] <= side_prev;
            end
        end

        if (g < STAGES - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g] <= rem_next;
                end
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign quo       = q_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

// File: src/anger_event_merge_core.sv
// Top level of the anger event merge block: detector map, reverse map and merge pipeline.
//
//  channel  | signals                        | word
//  ---------+--------------------------------+-----------------------------
//  item     | item_valid, item_ready, item   | load or merge command
//  result   | result_valid, result_ready, result | status, survivor, energy
//  config   | cfg_we, cfg_addr, cfg_data     | register write, no wait
//
// One item per cycle is accepted while item_ready is high; each passes through map read,
// product, six divider stages, three position multiplies, reverse map read and the
// result register before its result is valid.
// After reset a clearing pass writes the 1024 reverse map entries, one per cycle, and no
// item is accepted until the pass ends. An anger merge waits while a load is still in
// flight, since loads write the detector map late in the pipeline.
// A stalled result holds the whole pipeline, and item_ready drops in the same cycle.
`include "anger_event_merge_core_assert.svh"

module anger_event_merge_core #(
    parameter int NUM_DET = aem_pkg::NUM_DET
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  aem_pkg::in_word_t                   item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output aem_pkg::out_word_t                  result,
    input  logic                                cfg_we,
    input  logic [aem_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [aem_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import aem_pkg::*;

    localparam int AW         = $clog2(NUM_DET);
    localparam int PIPE_DEPTH = 2 + COORD_BITS + 4;
    localparam int LCNT_W     = $clog2(PIPE_DEPTH + 1);
    localparam int SIDE_W     = $bits(side_t);

    // Configuration registers.
    logic [MODE_W-1:0] mode_reg;
    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [CNT_W-1:0]  det_count_reg;
    logic [CNT_W-1:0]  bound;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_ANGER;
            size_x_reg    <= SIZE_W'(1);
            size_y_reg    <= SIZE_W'(1);
            size_z_reg    <= SIZE_W'(1);
            det_count_reg <= CNT_W'(1024);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MERGE_MODE: mode_reg      <= cfg_data[MODE_W-1:0];
                CFG_SIZE_X:     size_x_reg    <= cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y:     size_y_reg    <= cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z:     size_z_reg    <= cfg_data[SIZE_W-1:0];
                CFG_DET_COUNT:  det_count_reg <= cfg_data[CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    assign bound = (32'(det_count_reg) < NUM_DET) ? det_count_reg : CNT_W'(NUM_DET);

    // Pipeline control.
    logic              advance;
    logic              accept;
    logic              clr_active_reg, clr_active_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [LCNT_W-1:0] load_cnt_reg, load_cnt_next;
    logic              out_valid_reg;
    out_word_t         out_reg;

    logic s1_valid_reg, s2_valid_reg, m1_valid_reg, m2_valid_reg, r_valid_reg, w_valid_reg;
    logic div_valid;

    assign advance    = !out_valid_reg || result_ready;
    assign item_ready = advance && !clr_active_reg &&
                        !(item.cmd && mode_reg == MODE_ANGER && load_cnt_reg != '0);
    assign accept     = item_valid && item_ready;

    // Stage 1: detector map entries of both hits come back from the two map copies.
    in_word_t   s1_reg;
    map_entry_t map_a, map_b;
    map_entry_t w_pos;
    logic       dmap_we;
    logic [ID_W-1:0] w_det_a;

    aem_ram #(.WIDTH($bits(map_entry_t)), .DEPTH(NUM_DET)) u_dmap_a (
        .clk   (clk),
        .we    (dmap_we),
        .waddr (AW'(w_det_a)),
        .wdata (w_pos),
        .re    (advance),
        .raddr (AW'(item.det_a)),
        .rdata (map_a)
    );

    aem_ram #(.WIDTH($bits(map_entry_t)), .DEPTH(NUM_DET)) u_dmap_b (
        .clk   (clk),
        .we    (dmap_we),
        .waddr (AW'(w_det_a)),
        .wdata (w_pos),
        .re    (advance),
        .raddr (AW'(item.det_b)),
        .rdata (map_b)
    );

    side_t              s1_side;
    logic [ESUM_W-1:0]  s1_esum;
    logic               s1_da_ok, s1_db_ok;

    always_comb
    begin
        s1_esum  = ESUM_W'(s1_reg.energy_a) + ESUM_W'(s1_reg.energy_b);
        s1_da_ok = CNT_W'(s1_reg.det_a) < bound;
        s1_db_ok = CNT_W'(s1_reg.det_b) < bound;
        s1_side.is_load = !s1_reg.cmd;
        s1_side.anger   = s1_reg.cmd && mode_reg == MODE_ANGER;
        s1_side.id_ok   = s1_reg.cmd ? (s1_da_ok && s1_db_ok) : s1_da_ok;
        s1_side.s_zero  = s1_esum == '0;
        s1_side.keep    = s1_reg.cmd &&
                          (mode_reg == MODE_FIRST || s1_reg.energy_a >= s1_reg.energy_b);
        s1_side.det_a   = s1_reg.det_a;
        s1_side.det_b   = s1_reg.det_b;
        s1_side.esum    = s1_esum;
        if (s1_reg.cmd)
        begin
            s1_side.pos = map_a;
        end
        else
        begin
            s1_side.pos.blk = s1_reg.map_block;
            s1_side.pos.x   = s1_reg.map_x;
            s1_side.pos.y   = s1_reg.map_y;
            s1_side.pos.z   = s1_reg.map_z;
        end
    end

    // Stage 2: weighted coordinate products.
    side_t              s2_side_reg;
    logic [PROD_W-1:0]  pxa_reg, pxb_reg, pya_reg, pyb_reg, pza_reg, pzb_reg;
    logic [2:0][DIV_W-1:0] div_num;
    logic [DEN_W-1:0]   div_den;

    assign div_num[0] = ((DIV_W'(pxa_reg) + DIV_W'(pxb_reg)) << 1) + DIV_W'(s2_side_reg.esum);
    assign div_num[1] = ((DIV_W'(pya_reg) + DIV_W'(pyb_reg)) << 1) + DIV_W'(s2_side_reg.esum);
    assign div_num[2] = ((DIV_W'(pza_reg) + DIV_W'(pzb_reg)) << 1) + DIV_W'(s2_side_reg.esum);
    assign div_den    = DEN_W'(s2_side_reg.esum) << 1;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg      <= item;
            s2_side_reg <= s1_side;
            pxa_reg     <= PROD_W'(map_a.x) * PROD_W'(s1_reg.energy_a);
            pxb_reg     <= PROD_W'(map_b.x) * PROD_W'(s1_reg.energy_b);
            pya_reg     <= PROD_W'(map_a.y) * PROD_W'(s1_reg.energy_a);
            pyb_reg     <= PROD_W'(map_b.y) * PROD_W'(s1_reg.energy_b);
            pza_reg     <= PROD_W'(map_a.z) * PROD_W'(s1_reg.energy_a);
            pzb_reg     <= PROD_W'(map_b.z) * PROD_W'(s1_reg.energy_b);
        end
    end

    // Divider stages: rounded centroid per axis.
    logic [2:0][COORD_BITS-1:0] div_quo;
    logic [SIDE_W-1:0]          div_side_bits;
    side_t                      div_side;

    aem_cdiv #(.SIDE_W(SIDE_W)) u_cdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (s2_valid_reg),
        .num       (div_num),
        .den       (div_den),
        .side_in   (s2_side_reg),
        .out_valid (div_valid),
        .quo       (div_quo),
        .side_out  (div_side_bits)
    );

    assign div_side = side_t'(div_side_bits);

    // Position index: three multiply stages.
    side_t            m1_side, m1_side_reg, m2_side_reg, r_side_reg, w_side_reg;
    logic [T1_W-1:0]  t1_reg;
    logic [T2_W-1:0]  t2_reg;
    logic [POS_W-1:0] p_reg;
    logic             w_p_ok_reg;
    logic [AW-1:0]    w_p_idx_reg;

    always_comb
    begin
        m1_side = div_side;
        // Centroid replaces the first hit's position unless the total energy is zero.
        if (div_side.anger && !div_side.s_zero)
        begin
            m1_side.pos.x = div_quo[0];
            m1_side.pos.y = div_quo[1];
            m1_side.pos.z = div_quo[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m1_side_reg <= m1_side;
            t1_reg      <= T1_W'(m1_side.pos.blk) * T1_W'(size_z_reg) + T1_W'(m1_side.pos.z);
            m2_side_reg <= m1_side_reg;
            t2_reg      <= T2_W'(t1_reg) * T2_W'(size_y_reg) + T2_W'(m1_side_reg.pos.y);
            r_side_reg  <= m2_side_reg;
            p_reg       <= POS_W'(t2_reg) * POS_W'(size_x_reg) + POS_W'(m2_side_reg.pos.x);
            w_side_reg  <= r_side_reg;
            w_p_ok_reg  <= p_reg < POS_W'(bound);
            w_p_idx_reg <= p_reg[AW-1:0];
        end
    end

    // Reverse map: read at the position stage, decide and write one stage later.
    rev_entry_t    rev_rdata, rev_wdata, w_ent;
    logic          rev_we, w_write;
    logic [AW-1:0] rev_waddr;
    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    rev_entry_t    fwd_data_reg;
    status_t       w_status;
    logic [ID_W-1:0] w_mdet;

    aem_ram #(.WIDTH($bits(rev_entry_t)), .DEPTH(NUM_DET)) u_rmap (
        .clk   (clk),
        .we    (rev_we),
        .waddr (rev_waddr),
        .wdata (rev_wdata),
        .re    (advance),
        .raddr (p_reg[AW-1:0]),
        .rdata (rev_rdata)
    );

    always_comb
    begin
        // The entry written in the previous step is not yet in the read data.
        w_ent = (fwd_valid_reg && fwd_addr_reg == w_p_idx_reg) ? fwd_data_reg : rev_rdata;
        w_status = ST_OK;
        w_write  = 1'b0;
        w_mdet   = (w_side_reg.is_load || w_side_reg.keep) ? w_side_reg.det_a
                                                           : w_side_reg.det_b;
        if (w_side_reg.is_load)
        begin
            if (!w_side_reg.id_ok || !w_p_ok_reg)
            begin
                w_status = ST_RANGE;
            end
            else if (w_ent.valid && w_ent.id != w_side_reg.det_a)
            begin
                w_status = ST_DUP;
            end
            else
            begin
                w_write = w_valid_reg && advance;
            end
        end
        else if (w_side_reg.anger)
        begin
            if (!w_side_reg.id_ok)
            begin
                w_status = ST_RANGE;
            end
            else if (!w_p_ok_reg || !w_ent.valid)
            begin
                w_status = ST_UNMAPPED;
            end
            else
            begin
                w_mdet = w_ent.id;
            end
        end
    end

    assign dmap_we = w_write;
    assign w_det_a = w_side_reg.det_a;
    assign w_pos   = w_side_reg.pos;

    always_comb
    begin
        if (clr_active_reg)
        begin
            rev_we    = 1'b1;
            rev_waddr = clr_cnt_reg;
            rev_wdata = '0;
        end
        else
        begin
            rev_we          = w_write;
            rev_waddr       = w_p_idx_reg;
            rev_wdata.valid = 1'b1;
            rev_wdata.id    = w_side_reg.det_a;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fwd_addr_reg <= w_p_idx_reg;
            fwd_data_reg <= rev_wdata;
            out_reg.status        <= w_status;
            out_reg.keep_first    <= w_side_reg.keep;
            out_reg.merged_det    <= w_mdet;
            out_reg.merged_energy <= w_side_reg.is_load ? '0 : w_side_reg.esum;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Control registers.
    always_comb
    begin
        clr_cnt_next    = clr_cnt_reg;
        clr_active_next = clr_active_reg;
        if (clr_active_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (32'(clr_cnt_reg) == NUM_DET - 1)
            begin
                clr_active_next = 1'b0;
            end
        end
        load_cnt_next = load_cnt_reg;
        if (accept && !item.cmd)
        begin
            load_cnt_next = load_cnt_next + 1'b1;
        end
        if (advance && w_valid_reg && w_side_reg.is_load)
        begin
            load_cnt_next = load_cnt_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            load_cnt_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            m1_valid_reg   <= 1'b0;
            m2_valid_reg   <= 1'b0;
            r_valid_reg    <= 1'b0;
            w_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_cnt_reg    <= clr_cnt_next;
            load_cnt_reg   <= load_cnt_next;
            if (advance)
            begin
                s1_valid_reg  <= accept;
                s2_valid_reg  <= s1_valid_reg;
                m1_valid_reg  <= div_valid;
                m2_valid_reg  <= m1_valid_reg;
                r_valid_reg   <= m2_valid_reg;
                w_valid_reg   <= r_valid_reg;
                out_valid_reg <= w_valid_reg;
                fwd_valid_reg <= w_write;
            end
        end
    end

    `AEM_ASSERT_IMP(a_clear_blocks_input, clr_active_reg, !item_ready)
    `AEM_ASSERT_NXT(a_clear_runs_once, !clr_active_reg, !clr_active_reg)
    `AEM_ASSERT_IMP(a_load_cnt_bound, 1'b1, 32'(load_cnt_reg) <= PIPE_DEPTH)
    `AEM_ASSERT_IMP(a_rev_write_from_load, w_write, w_valid_reg && w_side_reg.is_load)

endmodule
